### design/srb_pkg.sv
// Shared types, codes and constants of the sequence reorder buffer.
package srb_pkg;

  localparam int CFG_W          = 9;
  localparam int CFG_IDX_W      = 1;
  localparam int SEQ_W          = 16;
  localparam int CNT_OUT_W      = 8;
  localparam int TOTAL_W        = 32;
  localparam int HANDLE_W       = 32;
  localparam int LENGTH_W       = 16;
  localparam int MAX_COUNTS_DEF = 256;

  // Remainder unit retires one dividend bit per cycle.
  localparam int DIV_STEPS = SEQ_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0] MODULO_RESET   = CFG_W'(256);
  localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(256);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MODULO   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_LIMIT = 1'b1;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_POPPED    = 3'd3,
    ST_POP_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    logic                      op;
    logic signed [SEQ_W-1:0]   seq_count;
    logic [HANDLE_W-1:0]       payload_handle;
    logic [LENGTH_W-1:0]       frame_length;
  } in_beat_t;

  typedef struct packed {
    status_t                   status;
    logic [CNT_OUT_W-1:0]      out_count;
    logic [HANDLE_W-1:0]       out_handle;
    logic [LENGTH_W-1:0]       out_length;
    logic [CNT_OUT_W-1:0]      skipped;
    logic [CFG_W-1:0]          occupancy;
    logic [TOTAL_W-1:0]        duplicate_total;
    logic [TOTAL_W-1:0]        overrun_total;
  } out_beat_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic div_step;
    logic push_exec;
    logic set_ptr;
    logic scan_adv;
    logic take;
    logic emit_empty;
    logic emit_read;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic op_pop;
    logic held_zero;
    logic full;
    logic hit;
    logic gap_done;
  } dp_stat_t;

endpackage

### design/srb_datapath.sv
// Datapath of the sequence reorder buffer: slot store, remainder unit, counters, result register.
module srb_datapath #(
  parameter int MAX_COUNTS = srb_pkg::MAX_COUNTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [srb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srb_pkg::CFG_W-1:0]       cfg_data,
  input  srb_pkg::in_beat_t               in_data,
  input  srb_pkg::dp_cmd_t                cmd,
  output srb_pkg::dp_stat_t               stat,
  output logic                            out_valid,
  output srb_pkg::out_beat_t              out_data
);
  import srb_pkg::*;

  localparam int IW = (MAX_COUNTS > 1) ? $clog2(MAX_COUNTS) : 1;
  localparam int CW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
  localparam logic [CW-1:0] MAX_CW = CW'(MAX_COUNTS);

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
  } slot_t;

  // Configuration
  logic [CFG_W-1:0] cfg_mod_r, cfg_cap_r;

  // Control state
  logic [MAX_COUNTS-1:0] valid_r, valid_nxt;
  logic [IW-1:0]         exp_r, exp_nxt;
  logic                  started_r, started_nxt;
  logic [CFG_W-1:0]      held_r, held_nxt;
  logic [TOTAL_W-1:0]    dup_r, dup_nxt;
  logic [TOTAL_W-1:0]    drop_r, drop_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Payload state
  slot_t                 mem [MAX_COUNTS];
  slot_t                 rd_r;
  logic                  op_r, neg_r;
  logic [HANDLE_W-1:0]   handle_r;
  logic [LENGTH_W-1:0]   length_r;
  logic [SEQ_W-1:0]      dvd_r;
  logic [CW-1:0]         rem_r;
  logic [IW-1:0]         ptr_r;
  logic [CW-1:0]         gap_r;
  out_beat_t             out_r;

  // Combinational
  logic [CW-1:0]   m;
  logic [CW:0]     div_t;
  logic [CW-1:0]   rem_step;
  logic [SEQ_W-1:0] seq_u, seq_abs;
  logic [CW-1:0]   c_fold;
  logic [IW-1:0]   c_idx;
  logic [CW-1:0]   exp_first;
  logic [CW-1:0]   rem_inc, next_ptr;
  logic [CW-1:0]   ptr_cw, ptr_inc, ptr_adv;
  logic            full, c_hit;
  status_t         push_status;

  // Effective modulo: zero reads as one, clamp to the store depth.
  always_comb begin
    m = CW'(cfg_mod_r);
    if (m == '0) begin
      m = CW'(1);
    end else if (m > MAX_CW) begin
      m = MAX_CW;
    end
  end

  // Restoring remainder step.
  assign div_t    = {rem_r, dvd_r[SEQ_W-1]};
  assign rem_step = (div_t >= {1'b0, m}) ? CW'(div_t - {1'b0, m}) : div_t[CW-1:0];

  assign seq_u   = in_data.seq_count;
  assign seq_abs = seq_u[SEQ_W-1] ? (~seq_u + 1'b1) : seq_u;

  // True modulo of a negative count.
  assign c_fold    = (neg_r && (rem_r != '0)) ? (m - rem_r) : rem_r;
  assign c_idx     = c_fold[IW-1:0];
  assign exp_first = (c_fold == '0) ? (m - CW'(1)) : (c_fold - CW'(1));
  assign full      = (held_r >= cfg_cap_r);
  assign c_hit     = valid_r[c_idx];

  assign rem_inc  = rem_r + CW'(1);
  assign next_ptr = (rem_inc == m) ? '0 : rem_inc;
  assign ptr_cw   = CW'(ptr_r);
  assign ptr_inc  = ptr_cw + CW'(1);
  assign ptr_adv  = (ptr_inc == m) ? '0 : ptr_inc;

  assign push_status = full ? ST_DROPPED : (c_hit ? ST_DUPLICATE : ST_INSERTED);

  assign stat.op_pop    = op_r;
  assign stat.held_zero = (held_r == '0);
  assign stat.full      = full;
  assign stat.hit       = valid_r[ptr_r];
  assign stat.gap_done  = (gap_r >= m);

  always_comb begin
    valid_nxt     = valid_r;
    exp_nxt       = exp_r;
    started_nxt   = started_r;
    held_nxt      = held_r;
    dup_nxt       = dup_r;
    drop_nxt      = drop_r;
    out_valid_nxt = cmd.push_exec | cmd.emit_empty | cmd.emit_read;
    if (cmd.push_exec) begin
      if (!started_r) begin
        exp_nxt     = exp_first[IW-1:0];
        started_nxt = 1'b1;
      end
      if (full) begin
        drop_nxt = drop_r + 1'b1;
      end else if (c_hit) begin
        dup_nxt = dup_r + 1'b1;
      end else begin
        valid_nxt[c_idx] = 1'b1;
        held_nxt         = held_r + 1'b1;
      end
    end
    if (cmd.take) begin
      valid_nxt[ptr_r] = 1'b0;
      held_nxt         = held_r - 1'b1;
      exp_nxt          = ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mod_r   <= MODULO_RESET;
      cfg_cap_r   <= CAPACITY_RESET;
      valid_r     <= '0;
      exp_r       <= '0;
      started_r   <= 1'b0;
      held_r      <= '0;
      dup_r       <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COUNT_MODULO:   cfg_mod_r <= cfg_data;
          CFG_CAPACITY_LIMIT: cfg_cap_r <= cfg_data;
          default:            cfg_mod_r <= cfg_mod_r;
        endcase
      end
      valid_r     <= valid_nxt;
      exp_r       <= exp_nxt;
      started_r   <= started_nxt;
      held_r      <= held_nxt;
      dup_r       <= dup_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Slot store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.push_exec && !full) begin
      mem[c_idx] <= '{handle: handle_r, length: length_r};
    end
    if (cmd.take) begin
      rd_r <= mem[ptr_r];
    end
  end

  // Beat latch, remainder unit, scan pointer and result fields.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_data.op;
      neg_r    <= (in_data.op == OP_PUSH) & seq_u[SEQ_W-1];
      handle_r <= in_data.payload_handle;
      length_r <= in_data.frame_length;
      dvd_r    <= (in_data.op == OP_POP) ? SEQ_W'(exp_r) : seq_abs;
      rem_r    <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[SEQ_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
    if (cmd.set_ptr) begin
      ptr_r <= next_ptr[IW-1:0];
      gap_r <= '0;
    end else if (cmd.scan_adv) begin
      ptr_r <= ptr_adv[IW-1:0];
      gap_r <= gap_r + CW'(1);
    end
    if (cmd.push_exec) begin
      out_r.status          <= push_status;
      out_r.out_count       <= '0;
      out_r.out_handle      <= '0;
      out_r.out_length      <= '0;
      out_r.skipped         <= '0;
      out_r.occupancy       <= held_nxt;
      out_r.duplicate_total <= dup_nxt;
      out_r.overrun_total   <= drop_nxt;
    end else if (cmd.emit_empty) begin
      out_r.status          <= ST_POP_EMPTY;
      out_r.out_count       <= '0;
      out_r.out_handle      <= '0;
      out_r.out_length      <= '0;
      out_r.skipped         <= '0;
      out_r.occupancy       <= held_r;
      out_r.duplicate_total <= dup_r;
      out_r.overrun_total   <= drop_r;
    end else if (cmd.take) begin
      out_r.status          <= ST_POPPED;
      out_r.out_count       <= ptr_cw[CNT_OUT_W-1:0];
      out_r.skipped         <= (gap_r > CW'(255)) ? {CNT_OUT_W{1'b1}} : gap_r[CNT_OUT_W-1:0];
      out_r.occupancy       <= held_nxt;
      out_r.duplicate_total <= dup_r;
      out_r.overrun_total   <= drop_r;
    end else if (cmd.emit_read) begin
      out_r.out_handle <= rd_r.handle;
      out_r.out_length <= rd_r.length;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### design/srb_ctrl.sv
// Controller state machine of the sequence reorder buffer.
module srb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  srb_pkg::dp_stat_t  stat,
  output srb_pkg::dp_cmd_t   cmd
);
  import srb_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_PUSH = 6'b000100,
    S_POP  = 6'b001000,
    S_SCAN = 6'b010000,
    S_READ = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = stat.op_pop ? S_POP : S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push_exec = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_POP: begin
        if (stat.held_zero) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.set_ptr = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          cmd.take  = 1'b1;
          state_nxt = S_READ;
        end else if (!stat.full || stat.gap_done) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_READ: begin
        cmd.emit_read = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### design/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer: controller plus datapath.
//
// Frames pushed with a sequence count come back out of pops in count order.
// A beat is taken when start is high and busy is low; busy stays high until
// the result beat has been registered. Every beat yields exactly one result
// beat, shown for one cycle with out_valid high; the receiver cannot stall,
// so capture it in that cycle. A push runs through the remainder unit, which
// folds the count one bit per cycle, and then updates the store. A pop also
// folds the last count handed out; it gives an empty result when the store is
// empty, or when the next slot is missing and the store is not full. Else a
// full store is scanned one slot per cycle until a held frame is found or the
// whole modulo has been passed without one, which also gives an empty result.
// A pop that hands out a frame then reads it through the registered read port
// of the slot memory. Write count_modulo and
// capacity_limit through the cfg port only while busy is low and no result is
// pending. Slot valid bits clear with reset, so no clearing pass is needed.
module sequence_reorder_buffer #(
  parameter int MAX_COUNTS = srb_pkg::MAX_COUNTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            start,
  output logic                            busy,
  input  srb_pkg::in_beat_t               in_data,
  // Result channel
  output logic                            out_valid,
  output srb_pkg::out_beat_t              out_data,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [srb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srb_pkg::CFG_W-1:0]       cfg_data
);
  import srb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence the fold, update and scan steps of each beat.
  srb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Hold slots, counters and configuration; drive the result beat.
  srb_datapath #(
    .MAX_COUNTS (MAX_COUNTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### bench/testbench.sv
// Testbench for the sequence reorder buffer: directed cases, then random traffic in phases.
`timescale 1ns / 100ps

module testbench;
  import srb_pkg::*;

  localparam int SLOT_CNT   = MAX_COUNTS_DEF;
  // Settle time before a register write or the end of the run.
  localparam int SETTLE_CYC = 4;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_beat_t   in_data   = '0;
  logic       out_valid;
  out_beat_t  out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  sequence_reorder_buffer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the buffer: registers, slot store, pointer and totals.
  logic [CFG_W-1:0]    modulo_q   = MODULO_RESET;
  logic [CFG_W-1:0]    capacity_q = CAPACITY_RESET;
  bit                  slot_full   [SLOT_CNT];
  logic [HANDLE_W-1:0] held_handle [SLOT_CNT];
  logic [LENGTH_W-1:0] held_length [SLOT_CNT];
  int unsigned         last_out   = 0;
  bit                  seq_armed  = 1'b0;
  int unsigned         held_cnt   = 0;
  logic [TOTAL_W-1:0]  dup_cnt    = '0;
  logic [TOTAL_W-1:0]  drop_cnt   = '0;

  // Result beats predicted for accepted commands, oldest first.
  out_beat_t due_replies[$];
  int        fail_count = 0;
  // Percent chance per draw that the sender holds off another stretch.
  int        idle_pct   = 0;

  // Clamp the modulo register into 1..SLOT_CNT.
  function automatic int unsigned cur_modulo();
    if (modulo_q == 0) return 1;
    if (modulo_q > SLOT_CNT) return SLOT_CNT;
    return modulo_q;
  endfunction

  // Apply one command to the shadow state and return the result beat it gives.
  function automatic out_beat_t reorder_step(in_beat_t b);
    out_beat_t   r;
    int unsigned m, c, nxt, gap;
    int          s, mi, rem;
    r  = '0;
    m  = cur_modulo();
    mi = int'(m);
    if (b.op == OP_PUSH) begin
      // Fold with true modulo so negative counts land in 0..m-1.
      s   = int'($signed(b.seq_count));
      rem = s % mi;
      if (rem < 0) rem += mi;
      c = rem;
      if (!seq_armed) begin
        last_out  = (c + m - 1) % m;
        seq_armed = 1'b1;
      end
      if (held_cnt < capacity_q) begin
        if (slot_full[c]) begin
          dup_cnt++;
          r.status = ST_DUPLICATE;
        end else begin
          slot_full[c] = 1'b1;
          held_cnt++;
          r.status = ST_INSERTED;
        end
        held_handle[c] = b.payload_handle;
        held_length[c] = b.frame_length;
      end else begin
        // Full store drops the frame, even when its count is already held.
        drop_cnt++;
        r.status = ST_DROPPED;
      end
    end else begin
      r.status = ST_POP_EMPTY;
      if (held_cnt > 0) begin
        nxt = (last_out % m + 1) % m;
        // A missing next count only waits while the store has room.
        if (slot_full[nxt] || held_cnt >= capacity_q) begin
          gap = 0;
          while (!slot_full[nxt] && gap < m) begin
            gap++;
            nxt = (nxt + 1) % m;
          end
          if (slot_full[nxt]) begin
            slot_full[nxt] = 1'b0;
            held_cnt--;
            last_out     = nxt;
            r.status     = ST_POPPED;
            r.out_count  = nxt[CNT_OUT_W-1:0];
            r.out_handle = held_handle[nxt];
            r.out_length = held_length[nxt];
            r.skipped    = (gap > 255) ? 8'd255 : gap[CNT_OUT_W-1:0];
          end
        end
      end
    end
    r.occupancy       = held_cnt[CFG_W-1:0];
    r.duplicate_total = dup_cnt;
    r.overrun_total   = drop_cnt;
    return r;
  endfunction

  // Offer one beat, hold it until accepted, and queue its prediction.
  task automatic send_beat(in_beat_t b);
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) repeat ($urandom_range(1, 8)) @(posedge clk);
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    due_replies.push_back(reorder_step(b));
    start <= 1'b0;
  endtask

  task automatic push_frame(int seq, logic [HANDLE_W-1:0] h, logic [LENGTH_W-1:0] len);
    in_beat_t b;
    b.op             = OP_PUSH;
    b.seq_count      = SEQ_W'(seq);
    b.payload_handle = h;
    b.frame_length   = len;
    send_beat(b);
  endtask

  task automatic pop_frame();
    in_beat_t b;
    b.op             = OP_POP;
    b.seq_count      = SEQ_W'($urandom);
    b.payload_handle = $urandom;
    b.frame_length   = LENGTH_W'($urandom);
    send_beat(b);
  endtask

  // Wait until every predicted beat has come back and the block sits idle.
  task automatic wait_idle();
    @(posedge clk);
    while (due_replies.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COUNT_MODULO) modulo_q = val;
    else capacity_q = val;
  endtask

  // Empty the store: full modulo and capacity one make every pop skip to a held frame.
  task automatic drain_store();
    write_cfg(CFG_COUNT_MODULO, CFG_W'(256));
    write_cfg(CFG_CAPACITY_LIMIT, CFG_W'(1));
    while (held_cnt > 0) pop_frame();
  endtask

  // Pop on an empty store, first push with the extreme counts, in-order pop, waiting pop.
  task automatic test_push_pop_basics();
    pop_frame();
    push_frame(-32768, 32'h0000_0000, 16'h0000);
    push_frame(32767, 32'h8000_0001, 16'h8001);
    pop_frame();
    pop_frame();
  endtask

  // Replace a held entry under the same folded count.
  task automatic test_duplicate_replace();
    push_frame(-1, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  // Full store: skip forward over empty counts, drop pushes, reach the widest skip.
  task automatic test_full_store_skip();
    write_cfg(CFG_CAPACITY_LIMIT, CFG_W'(1));
    pop_frame();
    push_frame(5, $urandom, LENGTH_W'($urandom));
    push_frame(5, $urandom, LENGTH_W'($urandom));
    pop_frame();
    push_frame(5, $urandom, LENGTH_W'($urandom));
    pop_frame();
  endtask

  // Capacity zero drops every push.
  task automatic test_capacity_zero();
    write_cfg(CFG_CAPACITY_LIMIT, CFG_W'(0));
    push_frame(16'h1234, $urandom, LENGTH_W'($urandom));
    pop_frame();
  endtask

  // Modulo register outside 1..256, and a negative count folded.
  task automatic test_modulo_range();
    write_cfg(CFG_CAPACITY_LIMIT, CFG_W'(511));
    write_cfg(CFG_COUNT_MODULO, CFG_W'(0));
    push_frame(-7, $urandom, LENGTH_W'($urandom));
    pop_frame();
    write_cfg(CFG_COUNT_MODULO, CFG_W'(511));
    push_frame(-300, $urandom, LENGTH_W'($urandom));
    pop_frame();
  endtask

  // Lower the modulo under held frames: a skipping pop finds nothing in range.
  task automatic test_modulo_lowered();
    push_frame(200, $urandom, LENGTH_W'($urandom));
    write_cfg(CFG_COUNT_MODULO, CFG_W'(16));
    write_cfg(CFG_CAPACITY_LIMIT, CFG_W'(2));
    pop_frame();
    push_frame(-1, $urandom, LENGTH_W'($urandom));
    drain_store();
  endtask

  // Mostly pushes near the next expected count plus pops, with some raw noise.
  task automatic run_traffic(int n_items);
    in_beat_t    b;
    int unsigned m;
    int          seq, wraps;
    for (int i = 0; i < n_items; i++) begin
      m = cur_modulo();
      if ($urandom_range(99) < 20) begin
        b.op             = 1'($urandom_range(1));
        b.seq_count      = SEQ_W'($urandom);
        b.payload_handle = $urandom;
        b.frame_length   = LENGTH_W'($urandom);
        send_beat(b);
      end else if ($urandom_range(99) < 40) begin
        pop_frame();
      end else begin
        wraps = $urandom_range(0, 9);
        seq   = int'(last_out) + 1 + int'($urandom_range(0, 5)) + int'(m) * (wraps - 5);
        push_frame(seq, $urandom, LENGTH_W'($urandom));
      end
    end
  endtask

  // Random phases over several register settings and sender idle rates.
  task automatic test_random_traffic();
    int unsigned mods  [6] = '{256, 16, 8, 300, 1, 64};
    int unsigned caps  [6] = '{256, 6, 8, 40, 2, 511};
    // The receiver cannot stall, so three of the phases run the sender flat out.
    int          idles [6] = '{0, 83, 0, 26, 0, 83};
    for (int p = 0; p < 6; p++) begin
      write_cfg(CFG_COUNT_MODULO, CFG_W'(mods[p]));
      write_cfg(CFG_CAPACITY_LIMIT, CFG_W'(caps[p]));
      idle_pct = idles[p];
      run_traffic(100);
      drain_store();
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare each result beat against the oldest prediction.
  always @(posedge clk) begin : check_replies
    out_beat_t want;
    if (rst_n && out_valid) begin
      if (due_replies.size() == 0) begin
        $error("result beat with no command outstanding");
        fail_count++;
      end else begin
        want = due_replies.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("out_count", 32'(want.out_count), 32'(out_data.out_count));
        check_field("out_handle", want.out_handle, out_data.out_handle);
        check_field("out_length", 32'(want.out_length), 32'(out_data.out_length));
        check_field("skipped", 32'(want.skipped), 32'(out_data.skipped));
        check_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
        check_field("duplicate_total", want.duplicate_total, out_data.duplicate_total);
        check_field("overrun_total", want.overrun_total, out_data.overrun_total);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_push_pop_basics();
    test_duplicate_replace();
    test_full_store_skip();
    test_capacity_zero();
    test_modulo_range();
    test_modulo_lowered();
    test_random_traffic();
    wait_idle();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && due_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #10000000;
    $display("status: fail");
    $finish;
  end

endmodule
